// File: rtl/gfa_pkg.sv
`timescale 1ns / 1ps
// Shared types, operation codes and field helpers for the GF(2^8) ALU.
// Depends on nothing; the ALU file takes names from here by scope.
package gfa_pkg;

  // Reduction constant for x^8 = x^4 + x^3 + x + 1, and the bit that shifts out.
  localparam logic [7:0] GF_REDUCE = 8'h1b;
  localparam logic [7:0] GF_TOPBIT = 8'h80;

  // Operation codes carried in the action field.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_MUL  = 3'd1;
  localparam logic [2:0] OP_MULX = 3'd2;
  localparam logic [2:0] OP_INV  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;

  // One pipeline stage: the operation, the dividend, two power-chain values
  // and the result of the single-stage operations.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] a;
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] res;
  } stage_t;

  // Multiply by x with reduction.
  function automatic logic [7:0] gf_times_x(input logic [7:0] v);
    logic [7:0] shifted;
    shifted = {v[6:0], 1'b0};
    if ((v & GF_TOPBIT) != 8'h00) begin
      shifted = shifted ^ GF_REDUCE;
    end
    return shifted;
  endfunction

  // Shift-and-add field multiply, most significant bit of y first.
  function automatic logic [7:0] gf_mul(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = gf_times_x(acc);
      if (y[i]) begin
        acc = acc ^ x;
      end
    end
    return acc;
  endfunction

  // Squaring is linear over GF(2); synthesis reduces it to an XOR network.
  function automatic logic [7:0] gf_sq(input logic [7:0] x);
    return gf_mul(x, x);
  endfunction

endpackage

// File: rtl/gfa_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the GF(2^8) ALU operands and results.
// Depends on nothing.

// Operand channel: action code and two field elements per beat.
interface gfa_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] a;
  logic [7:0] b;

  modport source (output valid, output action, output a, output b, input ready);
  modport sink   (input valid, input action, input a, input b, output ready);
endinterface

// Result channel: one field element per beat.
interface gfa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// File: rtl/gf256_field_alu.sv
`timescale 1ns / 1ps
// GF(2^8) arithmetic unit: add, multiply, multiply by x, inverse and divide.
// Depends on gfa_pkg and the channel interfaces in gfa_if.sv.
//
// The unit is a seven-stage pipeline that accepts one beat per cycle and
// returns each result from its last stage, both only while the
// result channel does not stall. The stage count is set by the inverse,
// a^254, which is built from a fixed chain of field multiplies and squarings with
// at most one full multiply plus one squaring per stage; divide adds its
// final multiply in the last stage. All operations pass through every stage,
// so results leave in order. When the result side stalls the whole pipeline
// holds, and in_bus.ready falls only while a finished result waits. Inverse
// of zero and division by zero yield zero; unused action codes yield zero.
module gf256_field_alu (
  input  logic      clk,
  input  logic      rst_n,
  gfa_in_if.sink    in_bus,
  gfa_out_if.source out_bus
);

  localparam int NSTAGE = 7;

  gfa_pkg::stage_t s_r   [NSTAGE];
  gfa_pkg::stage_t s_nxt [NSTAGE];
  logic [NSTAGE-1:0] v_r;
  logic              adv;
  logic [7:0]        x_in;
  logic [7:0]        x2_in;
  logic [7:0]        inv_fin;

  // The pipeline moves whenever the last stage is empty or being taken.
  assign adv          = !v_r[NSTAGE-1] || out_bus.ready;
  assign in_bus.ready = adv;

  // Divide inverts b; every other operation feeds a into the power chain.
  assign x_in  = (in_bus.action == gfa_pkg::OP_DIV) ? in_bus.b : in_bus.a;
  assign x2_in = gfa_pkg::gf_sq(x_in);

  // Final squaring gives the inverse.
  assign inv_fin = gfa_pkg::gf_sq(s_r[5].p);

  // Stage logic: each stage advances the power chain by one step.
  always_comb begin
    // Stage 1: a^2, a^3 and the single-step operations.
    s_nxt[0].op = in_bus.action;
    s_nxt[0].a  = in_bus.a;
    s_nxt[0].p  = x2_in;
    s_nxt[0].q  = gfa_pkg::gf_mul(x2_in, x_in);
    case (in_bus.action)
      gfa_pkg::OP_ADD:  s_nxt[0].res = in_bus.a ^ in_bus.b;
      gfa_pkg::OP_MUL:  s_nxt[0].res = gfa_pkg::gf_mul(in_bus.a, in_bus.b);
      gfa_pkg::OP_MULX: s_nxt[0].res = gfa_pkg::gf_times_x(in_bus.a);
      default:          s_nxt[0].res = 8'h00;
    endcase

    // Stage 2: a^4 and a^7.
    s_nxt[1]   = s_r[0];
    s_nxt[1].p = gfa_pkg::gf_sq(s_r[0].p);
    s_nxt[1].q = gfa_pkg::gf_mul(gfa_pkg::gf_sq(s_r[0].p), s_r[0].q);

    // Stage 3: a^15 = a^7 * a^8, keeping a^7.
    s_nxt[2]   = s_r[1];
    s_nxt[2].p = gfa_pkg::gf_mul(s_r[1].q, gfa_pkg::gf_sq(s_r[1].p));

    // Stage 4: a^30 and a^37 = a^7 * a^30.
    s_nxt[3]   = s_r[2];
    s_nxt[3].p = gfa_pkg::gf_sq(s_r[2].p);
    s_nxt[3].q = gfa_pkg::gf_mul(s_r[2].q, gfa_pkg::gf_sq(s_r[2].p));

    // Stage 5: a^60 and a^67 = a^37 * a^30.
    s_nxt[4]   = s_r[3];
    s_nxt[4].p = gfa_pkg::gf_sq(s_r[3].p);
    s_nxt[4].q = gfa_pkg::gf_mul(s_r[3].q, s_r[3].p);

    // Stage 6: a^127 = a^60 * a^67.
    s_nxt[5]   = s_r[4];
    s_nxt[5].p = gfa_pkg::gf_mul(s_r[4].p, s_r[4].q);

    // Stage 7: a^254, the divide multiply, and the result select.
    s_nxt[6] = s_r[5];
    case (s_r[5].op)
      gfa_pkg::OP_ADD,
      gfa_pkg::OP_MUL,
      gfa_pkg::OP_MULX: s_nxt[6].res = s_r[5].res;
      gfa_pkg::OP_INV:  s_nxt[6].res = inv_fin;
      gfa_pkg::OP_DIV:  s_nxt[6].res = gfa_pkg::gf_mul(s_r[5].a, inv_fin);
      default:          s_nxt[6].res = 8'h00;
    endcase
  end

  // Valid bits travel with the data; reset clears only the valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[NSTAGE-2:0], in_bus.valid};
    end
  end

  // Stage payload registers.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NSTAGE; i++) begin
        s_r[i] <= s_nxt[i];
      end
    end
  end

  // Result channel.
  assign out_bus.valid  = v_r[NSTAGE-1];
  assign out_bus.result = s_r[NSTAGE-1].res;

endmodule
